>>> hw/rtl/ptns_pkg.sv
`default_nettype none

package ptns_pkg;

   // Field widths of the request, response and configuration channels
   localparam int unsigned COORD_W    = 12;
   localparam int unsigned RADIUS_W   = 13;
   localparam int unsigned INDEX_W    = 6;
   localparam int unsigned DIST_W     = 25;
   localparam int unsigned RADIUS2_W  = 2 * RADIUS_W;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 13;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOT_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOT_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 2'd2;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_NEAREST = 2'd1,
      MODE_RADIUS  = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Tag that travels with one table entry down the distance pipe
   typedef struct packed {
      logic               vld;
      logic               last;
      logic [INDEX_W-1:0] idx;
   } tag_type;

endpackage

`default_nettype wire

>>> hw/rtl/ptns_dist_pipe.sv
`default_nettype none

// Two-stage squared distance: absolute differences, then squares; the sum
// of the squares is formed at the output.
module ptns_dist_pipe #(
   parameter int unsigned CW = 12
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 adv,
   input  wire ptns_pkg::tag_type              in_tag,
   input  wire [CW-1:0]                        entry_x,
   input  wire [CW-1:0]                        entry_y,
   input  wire [CW-1:0]                        query_x,
   input  wire [CW-1:0]                        query_y,
   output ptns_pkg::tag_type                   out_tag,
   output logic [ptns_pkg::DIST_W-1:0]         out_dist
);

   localparam int unsigned SQ_W = 2 * CW;

   ptns_pkg::tag_type a_tag_ff;
   ptns_pkg::tag_type b_tag_ff;
   logic [CW-1:0]     dx_ff;
   logic [CW-1:0]     dy_ff;
   logic [CW-1:0]     dx_in;
   logic [CW-1:0]     dy_in;
   logic [SQ_W-1:0]   sqx_ff;
   logic [SQ_W-1:0]   sqy_ff;

   always_comb begin
      dx_in = (entry_x > query_x) ? (entry_x - query_x) : (query_x - entry_x);
      dy_in = (entry_y > query_y) ? (entry_y - query_y) : (query_y - entry_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff.vld <= 1'b0;
         b_tag_ff.vld <= 1'b0;
      end else if (adv) begin
         a_tag_ff <= in_tag;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         b_tag_ff <= a_tag_ff;
         sqx_ff   <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
         sqy_ff   <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      end
   end

   assign out_tag  = b_tag_ff;
   assign out_dist = ptns_pkg::DIST_W'(sqx_ff) + ptns_pkg::DIST_W'(sqy_ff);

endmodule

`default_nettype wire

>>> hw/rtl/point_table_nearest_search.sv
// Insert and clear: the request moves control to the finish state, which loads
// the response register when not stalled; no new request is taken until idle.
// Nearest and radius queries: one table entry read per cycle from the point
// memory, over all N stored points; responses stall it.
// Reset: control clears, table holds only the root at (0,0), registers read zero.
// The point memory is not cleared; no clearing pass is needed after reset.
`default_nettype none

module point_table_nearest_search #(
   parameter int unsigned MAX_POINTS = 64,
   parameter int unsigned COORD_BITS = 12
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire [1:0]                             req_mode,
   input  wire [ptns_pkg::COORD_W-1:0]           req_point_x,
   input  wire [ptns_pkg::COORD_W-1:0]           req_point_y,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [ptns_pkg::INDEX_W-1:0]          rsp_node_index,
   output logic [ptns_pkg::DIST_W-1:0]           rsp_sq_distance,
   output logic                                  rsp_found,
   output logic                                  rsp_status,
   output logic                                  rsp_last,
   // configuration write port
   input  wire                                   csr_wr_en,
   input  wire [ptns_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire [ptns_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Effective coordinate width: fields are 12 bits, masked further below that
   localparam int unsigned CW   = (COORD_BITS < ptns_pkg::COORD_W) ?
                                  COORD_BITS : ptns_pkg::COORD_W;
   localparam int unsigned IW   = $clog2(MAX_POINTS);
   localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CW-1:0]                      root_x_cfg_ff;
   logic [CW-1:0]                      root_y_cfg_ff;
   logic [ptns_pkg::RADIUS2_W-1:0]     radius2_ff;

   // Square the radius once at write time so the scan only compares
   always_ff @(posedge clock) begin
      if (reset) begin
         root_x_cfg_ff <= '0;
         root_y_cfg_ff <= '0;
         radius2_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            ptns_pkg::CSR_ROOT_X: root_x_cfg_ff <= csr_wdata[CW-1:0];
            ptns_pkg::CSR_ROOT_Y: root_y_cfg_ff <= csr_wdata[CW-1:0];
            ptns_pkg::CSR_RADIUS: radius2_ff    <= ptns_pkg::RADIUS2_W'(csr_wdata) *
                                                   ptns_pkg::RADIUS2_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request capture and control state
   // ---------------------------------------------------------------------
   ptns_pkg::state_type state_ff;
   ptns_pkg::state_type state_in;
   ptns_pkg::mode_type  mode_ff;
   ptns_pkg::mode_type  req_mode_t;
   logic [CW-1:0]       query_x_ff;
   logic [CW-1:0]       query_y_ff;
   logic [CNTW-1:0]     count_ff;
   logic [CW-1:0]       root_x_ff;   // entry 0 lives in flops, reset to (0,0)
   logic [CW-1:0]       root_y_ff;
   logic                req_accept;
   logic                table_full;
   logic [IW-1:0]       last_idx;

   // Final-response fields for insert and clear
   logic [ptns_pkg::INDEX_W-1:0] fin_idx_ff;
   logic                         fin_found_ff;
   logic                         fin_status_ff;

   assign req_mode_t = ptns_pkg::mode_type'(req_mode);
   assign req_stall  = (state_ff != ptns_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff >= CNTW'(MAX_POINTS));
   assign last_idx   = IW'(count_ff - CNTW'(1));

   // Pipeline advance: freeze the scan pipeline while a response waits on a stall
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNTW'(1);
         root_x_ff <= '0;
         root_y_ff <= '0;
      end else if (req_accept) begin
         unique case (req_mode_t)
            ptns_pkg::MODE_INSERT: begin
               if (!table_full) begin
                  count_ff <= count_ff + CNTW'(1);
               end
            end
            ptns_pkg::MODE_CLEAR: begin
               count_ff  <= CNTW'(1);
               root_x_ff <= root_x_cfg_ff;
               root_y_ff <= root_y_cfg_ff;
            end
            default: ;
         endcase
      end
   end

   // Hold the request payload and the result of insert or clear
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff       <= req_mode_t;
         query_x_ff    <= req_point_x[CW-1:0];
         query_y_ff    <= req_point_y[CW-1:0];
         fin_idx_ff    <= '0;
         fin_found_ff  <= 1'b0;
         fin_status_ff <= 1'b0;
         if (req_mode_t == ptns_pkg::MODE_INSERT) begin
            if (table_full) begin
               fin_status_ff <= 1'b1;
            end else begin
               fin_idx_ff   <= ptns_pkg::INDEX_W'(count_ff);
               fin_found_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Point memory: one write port (insert), one registered read port (scan).
   // Entry 0 is never written; the root flops stand in for it.
   // ---------------------------------------------------------------------
   logic [2*CW-1:0] point_mem [MAX_POINTS];
   logic [2*CW-1:0] mem_rd_ff;
   logic [IW-1:0]   scan_idx_ff;
   logic            issue_done_ff;
   logic            issuing;

   always_ff @(posedge clock) begin
      if (req_accept && (req_mode_t == ptns_pkg::MODE_INSERT) && !table_full) begin
         point_mem[count_ff[IW-1:0]] <= {req_point_y[CW-1:0], req_point_x[CW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mem_rd_ff <= point_mem[scan_idx_ff];
      end
   end

   assign issuing = (state_ff == ptns_pkg::ST_SCAN) && !issue_done_ff;

   // Walk the table one entry per cycle while the pipeline advances
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
      end else if (req_accept) begin
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
      end else if (adv && issuing) begin
         if (scan_idx_ff == last_idx) begin
            issue_done_ff <= 1'b1;
         end else begin
            scan_idx_ff <= scan_idx_ff + IW'(1);
         end
      end
   end

   // Tag that lines up with the registered read data
   ptns_pkg::tag_type rd_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff.vld <= 1'b0;
      end else if (adv) begin
         rd_tag_ff.vld  <= issuing;
         rd_tag_ff.idx  <= ptns_pkg::INDEX_W'(scan_idx_ff);
         rd_tag_ff.last <= (scan_idx_ff == last_idx);
      end
   end

   // Select the root flops for entry 0
   logic [CW-1:0] entry_x;
   logic [CW-1:0] entry_y;

   always_comb begin
      if (rd_tag_ff.idx == '0) begin
         entry_x = root_x_ff;
         entry_y = root_y_ff;
      end else begin
         entry_x = mem_rd_ff[CW-1:0];
         entry_y = mem_rd_ff[2*CW-1:CW];
      end
   end

   ptns_pkg::tag_type            dist_tag;
   logic [ptns_pkg::DIST_W-1:0]  scan_dist;

   ptns_dist_pipe #(
      .CW (CW)
   ) u_dist_pipe (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (rd_tag_ff),
      .entry_x  (entry_x),
      .entry_y  (entry_y),
      .query_x  (query_x_ff),
      .query_y  (query_y_ff),
      .out_tag  (dist_tag),
      .out_dist (scan_dist)
   );

   // ---------------------------------------------------------------------
   // Reduction: running minimum for nearest, one-deep hold for radius so
   // the final qualifying entry can carry the last flag.
   // ---------------------------------------------------------------------
   logic                         dist_take;
   logic                         in_radius;
   logic [ptns_pkg::INDEX_W-1:0] best_idx_ff;
   logic [ptns_pkg::DIST_W-1:0]  best_dist_ff;
   logic                         pend_vld_ff;
   logic [ptns_pkg::INDEX_W-1:0] pend_idx_ff;
   logic [ptns_pkg::DIST_W-1:0]  pend_dist_ff;

   assign dist_take = (state_ff == ptns_pkg::ST_SCAN) && adv && dist_tag.vld;
   assign in_radius = ({1'b0, scan_dist} < radius2_ff);

   always_ff @(posedge clock) begin
      if (dist_take && (mode_ff == ptns_pkg::MODE_NEAREST)) begin
         // Strict compare keeps the lowest index on a tie
         if ((dist_tag.idx == '0) || (scan_dist < best_dist_ff)) begin
            best_idx_ff  <= dist_tag.idx;
            best_dist_ff <= scan_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (req_accept) begin
         pend_vld_ff <= 1'b0;
      end else if (dist_take && (mode_ff == ptns_pkg::MODE_RADIUS) && in_radius) begin
         pend_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_take && (mode_ff == ptns_pkg::MODE_RADIUS) && in_radius) begin
         pend_idx_ff  <= dist_tag.idx;
         pend_dist_ff <= scan_dist;
      end
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptns_pkg::ST_IDLE: begin
            if (req_accept) begin
               if ((req_mode_t == ptns_pkg::MODE_NEAREST) ||
                   (req_mode_t == ptns_pkg::MODE_RADIUS)) begin
                  state_in = ptns_pkg::ST_SCAN;
               end else begin
                  state_in = ptns_pkg::ST_FINISH;
               end
            end
         end
         ptns_pkg::ST_SCAN: begin
            if (dist_take && dist_tag.last) begin
               state_in = ptns_pkg::ST_FINISH;
            end
         end
         ptns_pkg::ST_FINISH: begin
            if (adv) begin
               state_in = ptns_pkg::ST_IDLE;
            end
         end
         default: state_in = ptns_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptns_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic                         rsp_load;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [ptns_pkg::INDEX_W-1:0] rsp_idx_in;
   logic [ptns_pkg::DIST_W-1:0]  rsp_dist_in;
   logic                         rsp_found_in;
   logic                         rsp_status_in;
   logic                         rsp_last_in;
   logic [ptns_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic [ptns_pkg::DIST_W-1:0]  rsp_dist_ff;
   logic                         rsp_found_ff;
   logic                         rsp_status_ff;
   logic                         rsp_last_ff;

   always_comb begin
      rsp_load      = 1'b0;
      rsp_idx_in    = '0;
      rsp_dist_in   = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = 1'b0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ptns_pkg::ST_SCAN: begin
            // A new hit releases the held one, which is then not the last
            if (dist_take && (mode_ff == ptns_pkg::MODE_RADIUS) && in_radius &&
                pend_vld_ff) begin
               rsp_load     = 1'b1;
               rsp_idx_in   = pend_idx_ff;
               rsp_dist_in  = pend_dist_ff;
               rsp_found_in = 1'b1;
               rsp_last_in  = 1'b0;
            end
         end
         ptns_pkg::ST_FINISH: begin
            rsp_load = adv;
            unique case (mode_ff)
               ptns_pkg::MODE_NEAREST: begin
                  rsp_idx_in   = best_idx_ff;
                  rsp_dist_in  = best_dist_ff;
                  rsp_found_in = 1'b1;
               end
               ptns_pkg::MODE_RADIUS: begin
                  // Nothing in range: report not found
                  if (pend_vld_ff) begin
                     rsp_idx_in   = pend_idx_ff;
                     rsp_dist_in  = pend_dist_ff;
                     rsp_found_in = 1'b1;
                  end
               end
               default: begin
                  rsp_idx_in    = fin_idx_ff;
                  rsp_found_in  = fin_found_ff;
                  rsp_status_in = fin_status_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff    <= rsp_idx_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_idx_ff;
   assign rsp_sq_distance = rsp_dist_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire
